@@ rtl/cssq_pkg.sv @@
// ----------------------------------------------------------------------------
// cssq_pkg: shared types and constants for the clock-synced step sequencer
// Command codes, sequencer states, memory control group and rate masks.
// ----------------------------------------------------------------------------
package cssq_pkg;

  // Default sizes
  localparam int TRACKS_DEF = 8;
  localparam int STEPS_DEF  = 16;

  // 24 pulses per quarter note; the phase counts 0..23
  localparam int PPQN    = 24;
  localparam int PHASE_W = 5;
  localparam int VALUE_W = 8;

  // Rate codes
  localparam logic [2:0] RATE_QUARTER        = 3'd0;
  localparam logic [2:0] RATE_EIGHTH         = 3'd1;
  localparam logic [2:0] RATE_EIGHTH_TRIP    = 3'd2;
  localparam logic [2:0] RATE_SIXTEENTH      = 3'd3;
  localparam logic [2:0] RATE_SIXTEENTH_TRIP = 3'd4;
  localparam logic [2:0] RATE_THIRTYSECOND   = 3'd5;

  // Command codes
  typedef enum logic [2:0] {
    FN_TICK  = 3'd0,
    FN_START = 3'd1,
    FN_STOP  = 3'd2,
    FN_ARM   = 3'd3,
    FN_WRITE = 3'd4,
    FN_RATE  = 3'd5
  } func_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WALK,
    ST_READ
  } state_t;

  // Step value memory control
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

  // Phases at which a track of the given rate advances (bit p set: p % ticks == 0)
  function automatic logic [PPQN-1:0] phase_mask(input logic [2:0] rate);
    logic [PPQN-1:0] m;
    case (rate)
      RATE_QUARTER:        m = 24'h000001;  // every 24 ticks
      RATE_EIGHTH:         m = 24'h001001;  // every 12 ticks
      RATE_EIGHTH_TRIP:    m = 24'h010101;  // every 8 ticks
      RATE_SIXTEENTH:      m = 24'h041041;  // every 6 ticks
      RATE_SIXTEENTH_TRIP: m = 24'h111111;  // every 4 ticks
      RATE_THIRTYSECOND:   m = 24'h249249;  // every 3 ticks
      default:             m = 24'h041041;  // unused codes act as sixteenth
    endcase
    return m;
  endfunction

endpackage

@@ rtl/cssq_cmd_if.sv @@
// ----------------------------------------------------------------------------
// cssq_cmd_if: command channel
// Valid/ready channel carrying one sequencer command per transaction.
// ----------------------------------------------------------------------------
interface cssq_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [2:0] track;
  logic [3:0] step_index;
  logic [7:0] value;
  logic [2:0] rate;
  logic       arm_on;

  modport source (
    output valid, func, track, step_index, value, rate, arm_on,
    input  ready
  );

  modport sink (
    input  valid, func, track, step_index, value, rate, arm_on,
    output ready
  );
endinterface

@@ rtl/cssq_res_if.sv @@
// ----------------------------------------------------------------------------
// cssq_res_if: result channel
// Valid/ready channel carrying one step event per transaction.
// ----------------------------------------------------------------------------
interface cssq_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_track;
  logic [3:0] out_step;
  logic [7:0] out_value;
  logic       last;

  modport source (
    output valid, out_track, out_step, out_value, last,
    input  ready
  );

  modport sink (
    input  valid, out_track, out_step, out_value, last,
    output ready
  );
endinterface

@@ rtl/clock_synced_step_sequencer.sv @@
// Timing: a non-tick command or a stopped tick is done in the idle state. A running tick
//   scans every track through the check, then walks the tracks, reading the value of each
//   advancing track into the output register; it stalls while the result side stalls.
// Throughput: one command at a time, set by the per-track scan and walk through
//   the shared check unit and the single read port of the step memory.
// Reset: synchronous; all TRACKS*STEPS step memory entries (128 at defaults) are cleared first.
// ----------------------------------------------------------------------------
// clock_synced_step_sequencer: multi-track step sequencer on a 24 PPQN clock
// Sequencer control, shared advance check and step value memory.
// ----------------------------------------------------------------------------
module clock_synced_step_sequencer #(
  parameter int TRACKS = cssq_pkg::TRACKS_DEF,
  parameter int STEPS  = cssq_pkg::STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cssq_cmd_if.sink   cmd,
  cssq_res_if.source res
);

  localparam int DEPTH = TRACKS * STEPS;
  localparam int AW    = $clog2(DEPTH);

  cssq_pkg::mem_ctrl_t          mem_ctl;
  logic [AW-1:0]                wr_addr;
  logic [cssq_pkg::VALUE_W-1:0] wr_data;
  logic [AW-1:0]                rd_addr;
  logic [cssq_pkg::VALUE_W-1:0] rd_data;
  logic                         chk_armed;
  logic [2:0]                   chk_rate;
  logic [cssq_pkg::PHASE_W-1:0] chk_phase;
  logic                         chk_hit;

  cssq_ctrl #(
    .TRACKS (TRACKS),
    .STEPS  (STEPS),
    .DEPTH  (DEPTH),
    .AW     (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (res),
    .mem_ctl   (mem_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .chk_armed (chk_armed),
    .chk_rate  (chk_rate),
    .chk_phase (chk_phase),
    .chk_hit   (chk_hit)
  );

  cssq_check u_check (
    .armed (chk_armed),
    .rate  (chk_rate),
    .phase (chk_phase),
    .hit   (chk_hit)
  );

  cssq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

@@ rtl/cssq_check.sv @@
// ----------------------------------------------------------------------------
// cssq_check: shared advance check
// Decides whether one track steps at the current tick phase.
// ----------------------------------------------------------------------------
module cssq_check (
  input  logic                        armed,
  input  logic [2:0]                  rate,
  input  logic [cssq_pkg::PHASE_W-1:0] phase,
  output logic                        hit
);

  logic [cssq_pkg::PPQN-1:0] mask;

  // Divisibility by ticks-per-step, looked up as a phase pattern
  always_comb begin
    mask = cssq_pkg::phase_mask(rate);
    hit  = armed && mask[phase];
  end

endmodule

@@ rtl/cssq_mem.sv @@
// ----------------------------------------------------------------------------
// cssq_mem: step value memory
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module cssq_mem #(
  parameter int DEPTH = cssq_pkg::TRACKS_DEF * cssq_pkg::STEPS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  cssq_pkg::mem_ctrl_t         ctl,
  input  logic [AW-1:0]               wr_addr,
  input  logic [cssq_pkg::VALUE_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [cssq_pkg::VALUE_W-1:0] rd_data
);

  logic [cssq_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/cssq_ctrl.sv @@
// ----------------------------------------------------------------------------
// cssq_ctrl: sequencer control
// Command decode, track state, per-track scan and walk, output register.
// ----------------------------------------------------------------------------
module cssq_ctrl #(
  parameter int TRACKS = cssq_pkg::TRACKS_DEF,
  parameter int STEPS  = cssq_pkg::STEPS_DEF,
  parameter int DEPTH  = TRACKS * STEPS,
  parameter int AW     = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  cssq_cmd_if.sink                     cmd,
  cssq_res_if.source                   res,
  // step value memory
  output cssq_pkg::mem_ctrl_t          mem_ctl,
  output logic [AW-1:0]                wr_addr,
  output logic [cssq_pkg::VALUE_W-1:0] wr_data,
  output logic [AW-1:0]                rd_addr,
  input  logic [cssq_pkg::VALUE_W-1:0] rd_data,
  // shared advance check
  output logic                         chk_armed,
  output logic [2:0]                   chk_rate,
  output logic [cssq_pkg::PHASE_W-1:0] chk_phase,
  input  logic                         chk_hit
);

  localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int SW = $clog2(STEPS);

  cssq_pkg::state_t state, state_next;

  logic [TW-1:0]                idx;
  logic [AW-1:0]                clr_addr;
  logic [cssq_pkg::PHASE_W-1:0] phase;
  logic                         running;
  logic [TRACKS-1:0]            armed;
  logic [2:0]                   rates    [TRACKS];
  logic [SW-1:0]                cur_step [TRACKS];
  logic [TRACKS-1:0]            mask;
  logic [SW-1:0]                hold_step;
  logic                         hold_last;

  // output register
  logic                         ov;
  logic [2:0]                   o_track;
  logic [3:0]                   o_step;
  logic [cssq_pkg::VALUE_W-1:0] o_value;
  logic                         o_last;

  logic              cmd_fire;
  logic              idx_last;
  logic              trk_ok;
  logic              stp_ok;
  logic [TW-1:0]     trk_i;
  logic [SW-1:0]     stp_i;
  logic [SW-1:0]     cur;
  logic [SW-1:0]     ns;
  logic [TRACKS-1:0] mask_rest;
  logic              last_hit;
  logic              out_free;

  // Decode and per-track datapath
  always_comb begin
    cmd_fire  = cmd.valid && cmd.ready;
    idx_last  = (idx == TW'(TRACKS - 1));
    trk_ok    = (32'(cmd.track) < TRACKS);
    stp_ok    = (32'(cmd.step_index) < STEPS);
    trk_i     = TW'(cmd.track);
    stp_i     = SW'(cmd.step_index);
    cur       = cur_step[idx];
    ns        = (cur == SW'(STEPS - 1)) ? '0 : cur + SW'(1);
    mask_rest = mask & ~(TRACKS'(1) << idx);
    last_hit  = (mask_rest == '0);
    out_free  = !ov || res.ready;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cssq_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = cssq_pkg::ST_IDLE;
      end
      cssq_pkg::ST_IDLE: begin
        if (cmd_fire && cmd.func == cssq_pkg::FN_TICK && running) begin
          state_next = cssq_pkg::ST_SCAN;
        end
      end
      cssq_pkg::ST_SCAN: begin
        if (idx_last) state_next = cssq_pkg::ST_WALK;
      end
      cssq_pkg::ST_WALK: begin
        if (mask[idx]) begin
          state_next = cssq_pkg::ST_READ;
        end else if (idx_last) begin
          state_next = cssq_pkg::ST_IDLE;
        end
      end
      cssq_pkg::ST_READ: begin
        if (out_free) begin
          state_next = hold_last ? cssq_pkg::ST_IDLE : cssq_pkg::ST_WALK;
        end
      end
      default: state_next = cssq_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshakes, memory ports, check operands
  always_comb begin
    cmd.ready     = (state == cssq_pkg::ST_IDLE);
    res.valid     = ov;
    res.out_track = o_track;
    res.out_step  = o_step;
    res.out_value = o_value;
    res.last      = o_last;

    mem_ctl.wr_en = (state == cssq_pkg::ST_CLEAR) ||
                    (cmd_fire && cmd.func == cssq_pkg::FN_WRITE && trk_ok && stp_ok);
    mem_ctl.rd_en = (state == cssq_pkg::ST_WALK) && mask[idx];
    wr_addr       = (state == cssq_pkg::ST_CLEAR) ? clr_addr
                                                  : AW'(32'(trk_i) * STEPS + 32'(stp_i));
    wr_data       = (state == cssq_pkg::ST_CLEAR) ? '0 : cmd.value;
    rd_addr       = AW'(32'(idx) * STEPS + 32'(ns));

    chk_armed     = armed[idx];
    chk_rate      = rates[idx];
    chk_phase     = phase;
  end

  // Control and track state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cssq_pkg::ST_CLEAR;
      clr_addr <= '0;
      idx      <= '0;
      phase    <= '0;
      running  <= 1'b0;
      armed    <= '0;
      mask     <= '0;
      ov       <= 1'b0;
      for (int t = 0; t < TRACKS; t++) begin
        rates[t]    <= cssq_pkg::RATE_SIXTEENTH;
        cur_step[t] <= '0;
      end
    end else begin
      state <= state_next;
      case (state)
        cssq_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
        end
        cssq_pkg::ST_IDLE: begin
          if (cmd_fire) begin
            case (cmd.func)
              cssq_pkg::FN_TICK: begin
                if (running) begin
                  phase <= (phase == cssq_pkg::PHASE_W'(cssq_pkg::PPQN - 1)) ?
                           '0 : phase + cssq_pkg::PHASE_W'(1);
                  idx   <= '0;
                end
              end
              cssq_pkg::FN_START: begin
                phase   <= '0;
                running <= 1'b1;
                for (int t = 0; t < TRACKS; t++) cur_step[t] <= '0;
              end
              cssq_pkg::FN_STOP: begin
                running <= 1'b0;
              end
              cssq_pkg::FN_ARM: begin
                if (trk_ok) begin
                  armed[trk_i] <= cmd.arm_on;
                  if (cmd.arm_on) cur_step[trk_i] <= '0;
                end
              end
              cssq_pkg::FN_RATE: begin
                if (trk_ok) rates[trk_i] <= cmd.rate;
              end
              default: ;
            endcase
          end
        end
        // one track through the shared check per cycle
        cssq_pkg::ST_SCAN: begin
          mask[idx] <= chk_hit;
          idx       <= idx_last ? '0 : idx + TW'(1);
        end
        // advance a hit track and fetch its value, else skip on
        cssq_pkg::ST_WALK: begin
          if (mask[idx]) begin
            cur_step[idx] <= ns;
            mask[idx]     <= 1'b0;
            hold_step     <= ns;
            hold_last     <= last_hit;
          end else if (!idx_last) begin
            idx <= idx + TW'(1);
          end
        end
        cssq_pkg::ST_READ: begin
          if (out_free && !hold_last) idx <= idx + TW'(1);
        end
        default: ;
      endcase

      // output register
      if (state == cssq_pkg::ST_READ && out_free) begin
        ov <= 1'b1;
      end else if (res.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == cssq_pkg::ST_READ && out_free) begin
      o_track <= 3'(idx);
      o_step  <= 4'(hold_step);
      o_value <= rd_data;
      o_last  <= hold_last;
    end
  end

endmodule
